// ----- hdl/okcgc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okcgc_pkg
// shared widths, coefficient tables and the beat type for the oklab chroma clamp
// ----------------------------------------------------------------------------
package okcgc_pkg;

  localparam int BisectSteps = 5;
  localparam int FracBits    = 14;
  localparam int PixW        = 16;
  localparam int TW          = BisectSteps + 1;
  localparam int CoefW       = 20;
  localparam int CoefOneSh   = 16;
  localparam int StepStages  = 7;

  localparam int ProdW  = PixW + TW + 1;
  localparam int MixW   = CoefW + ProdW;
  localparam int AccW   = MixW + 2;
  localparam int LmsSh  = FracBits + BisectSteps;
  localparam int LmsW   = 20;
  localparam int LmsLimit = 4 * 65536;
  localparam int SqW    = 2 * LmsW - 2;
  localparam int CubePW = SqW + LmsW;
  localparam int CubeSh = 32;
  localparam int CubeW  = 24;
  localparam int RgbPW  = CoefW + CubeW;
  localparam int RgbW   = RgbPW + 2;

  localparam longint unsigned TenPowTen  = 64'd10000000000;
  localparam longint unsigned GreyLimit  = 64'd1 << (2 * FracBits);
  localparam longint unsigned GreyThresh = (GreyLimit + TenPowTen - 64'd1) / TenPowTen;

  localparam logic [TW-1:0] THi = TW'(1) << BisectSteps;

  // oklab (a, b) columns to cube-root lms, q.16; the l column is one
  localparam logic signed [CoefW-1:0] LabToLms [3][2] = '{
    '{20'sd25974,  20'sd14143},
    '{-20'sd6918,  -20'sd4185},
    '{-20'sd5864,  -20'sd84639}
  };

  // lms to linear rgb, q.16
  localparam logic signed [CoefW-1:0] LmsToRgb [3][3] = '{
    '{20'sd267173, -20'sd216774, 20'sd15137},
    '{-20'sd83128, 20'sd171033,  -20'sd22369},
    '{-20'sd275,   -20'sd46099,  20'sd111910}
  };

  typedef struct packed {
    logic signed [PixW-1:0] l;
    logic signed [PixW-1:0] a;
    logic signed [PixW-1:0] b;
    logic                   grey;
    logic [TW-1:0]          lo;
    logic [TW-1:0]          hi;
  } item_t;

endpackage

// ----- hdl/okcgc_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okcgc_step
// one bisection step: trial point to lms, cube, rgb, gamut test, bound update
// ----------------------------------------------------------------------------
module okcgc_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  okcgc_pkg::item_t    item_i,
  output logic                valid_o,
  output okcgc_pkg::item_t    item_o
);

  localparam int AccW   = okcgc_pkg::AccW;
  localparam int CubePW = okcgc_pkg::CubePW;
  localparam int LmsW   = okcgc_pkg::LmsW;
  localparam int RgbW   = okcgc_pkg::RgbW;
  localparam int NSt    = okcgc_pkg::StepStages;

  localparam logic signed [AccW:0] LmsHi = (AccW+1)'(okcgc_pkg::LmsLimit);
  localparam logic signed [AccW:0] LmsLo = -((AccW+1)'(okcgc_pkg::LmsLimit));
  localparam logic signed [RgbW-1:0] GamutOne = RgbW'(64'd1 << 32);

  function automatic logic signed [LmsW-1:0] lms_round_sat(
    input logic signed [AccW-1:0] acc
  );
    logic [AccW-1:0]       mag;
    logic [AccW-1:0]       r;
    logic signed [AccW:0]  s;
    mag = acc[AccW-1] ? AccW'(-acc) : AccW'(acc);
    r   = (mag + (AccW'(1) << (okcgc_pkg::LmsSh - 1))) >> okcgc_pkg::LmsSh;
    s   = acc[AccW-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    if (s > LmsHi) s = LmsHi;
    if (s < LmsLo) s = LmsLo;
    return s[LmsW-1:0];
  endfunction

  function automatic logic signed [okcgc_pkg::CubeW-1:0] cube_round(
    input logic signed [CubePW-1:0] p
  );
    logic [CubePW-1:0]      mag;
    logic [CubePW-1:0]      r;
    logic signed [CubePW:0] s;
    mag = p[CubePW-1] ? CubePW'(-p) : CubePW'(p);
    r   = (mag + (CubePW'(1) << (okcgc_pkg::CubeSh - 1))) >> okcgc_pkg::CubeSh;
    s   = p[CubePW-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    return s[okcgc_pkg::CubeW-1:0];
  endfunction

  okcgc_pkg::item_t it_q [NSt];
  logic [NSt-1:0]   vld_q;

  logic signed [okcgc_pkg::ProdW-1:0]  at_q, bt_q;
  logic signed [okcgc_pkg::MixW-1:0]   pa_q [3];
  logic signed [okcgc_pkg::MixW-1:0]   pb_q [3];
  logic signed [LmsW-1:0]              v_q  [3];
  logic signed [LmsW-1:0]              v2_q [3];
  logic signed [okcgc_pkg::SqW-1:0]    sq_q [3];
  logic signed [okcgc_pkg::CubeW-1:0]  lms_q [3];
  logic signed [okcgc_pkg::RgbPW-1:0]  rp_q [3][3];

  logic [okcgc_pkg::TW:0]    mid_sum;
  logic [okcgc_pkg::TW-1:0]  mid_in, mid_last;
  logic signed [AccW-1:0]    lterm;
  logic [2:0]                chan_ok;
  logic signed [RgbW-1:0]    rgb_sum [3];
  okcgc_pkg::item_t          it_last;

  assign mid_sum = {1'b0, item_i.lo} + {1'b0, item_i.hi};
  assign mid_in  = mid_sum[okcgc_pkg::TW:1];
  assign lterm   = AccW'(it_q[1].l) <<< (okcgc_pkg::CoefOneSh + okcgc_pkg::BisectSteps);

  logic [okcgc_pkg::TW:0] mid_sum_last;
  assign mid_sum_last = {1'b0, it_q[NSt-2].lo} + {1'b0, it_q[NSt-2].hi};
  assign mid_last     = mid_sum_last[okcgc_pkg::TW:1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rgb_sum[i] = RgbW'(rp_q[i][0]) + RgbW'(rp_q[i][1]) + RgbW'(rp_q[i][2]);
      chan_ok[i] = !rgb_sum[i][RgbW-1] && (rgb_sum[i] <= GamutOne);
    end
  end

  // bound update: in gamut moves the lower bound, otherwise the upper
  always_comb begin
    it_last = it_q[NSt-2];
    if (&chan_ok) begin
      it_last.lo = mid_last;
    end else begin
      it_last.hi = mid_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSt-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it_q[0] <= item_i;
      for (int s = 1; s < NSt - 1; s++) it_q[s] <= it_q[s-1];
      it_q[NSt-1] <= it_last;

      at_q <= item_i.a * $signed({1'b0, mid_in});
      bt_q <= item_i.b * $signed({1'b0, mid_in});
      for (int i = 0; i < 3; i++) begin
        pa_q[i]  <= okcgc_pkg::LabToLms[i][0] * at_q;
        pb_q[i]  <= okcgc_pkg::LabToLms[i][1] * bt_q;
        v_q[i]   <= lms_round_sat(lterm + AccW'(pa_q[i]) + AccW'(pb_q[i]));
        sq_q[i]  <= okcgc_pkg::SqW'(v_q[i] * v_q[i]);
        v2_q[i]  <= v_q[i];
        lms_q[i] <= cube_round(CubePW'(sq_q[i] * v2_q[i]));
        for (int j = 0; j < 3; j++) begin
          rp_q[i][j] <= okcgc_pkg::LmsToRgb[i][j] * lms_q[j];
        end
      end
    end
  end

  assign valid_o = vld_q[NSt-1];
  assign item_o  = it_q[NSt-1];

endmodule

// ----- hdl/oklab_chroma_gamut_clamp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oklab_chroma_gamut_clamp
// reduces oklab chroma by bisection until the pixel lies in the rgb gamut
// ----------------------------------------------------------------------------
// pipeline: 5 bisection steps of 7 register stages each, then 1 output register
// throughput: one beat per cycle, the whole pipeline stalls while the output
//   register holds a beat that is not taken
// reset: rst_ni clears all valid bits, payload registers are not reset
module oklab_chroma_gamut_clamp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // lightness_in, green_red_in, blue_yellow_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o    // lightness_out, green_red_out, blue_yellow_out
);

  localparam int NSteps = okcgc_pkg::BisectSteps;
  localparam int PixW   = okcgc_pkg::PixW;
  localparam int SclW   = PixW + okcgc_pkg::TW + 1;

  logic                en;
  logic                out_vld_q;
  logic [47:0]         out_data_q;

  logic                vld [NSteps+1];
  okcgc_pkg::item_t    itm [NSteps+1];
  okcgc_pkg::item_t    itm_in;

  logic signed [2*PixW-1:0] asq, bsq;
  logic [2*PixW:0]          csq;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  assign asq = $signed(s_axis_tdata_i[31:16]) * $signed(s_axis_tdata_i[31:16]);
  assign bsq = $signed(s_axis_tdata_i[47:32]) * $signed(s_axis_tdata_i[47:32]);
  assign csq = {1'b0, asq} + {1'b0, bsq};

  always_comb begin
    itm_in.l    = s_axis_tdata_i[15:0];
    itm_in.a    = s_axis_tdata_i[31:16];
    itm_in.b    = s_axis_tdata_i[47:32];
    itm_in.grey = 64'(csq) < okcgc_pkg::GreyThresh;
    itm_in.lo   = '0;
    itm_in.hi   = okcgc_pkg::THi;
  end

  assign vld[0] = s_axis_tvalid_i;
  assign itm[0] = itm_in;

  for (genvar g = 0; g < NSteps; g++) begin : g_step
    okcgc_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[g]),
      .item_i  (itm[g]),
      .valid_o (vld[g+1]),
      .item_o  (itm[g+1])
    );
  end

  // scale by t_lo, truncating toward zero
  function automatic logic [PixW-1:0] scale_trunc(
    input logic signed [PixW-1:0]   v,
    input logic [okcgc_pkg::TW-1:0] t
  );
    logic signed [SclW-1:0] p;
    logic [SclW-1:0]        m;
    logic [SclW-1:0]        r;
    p = v * $signed({1'b0, t});
    m = p[SclW-1] ? SclW'(-p) : SclW'(p);
    r = m >> okcgc_pkg::BisectSteps;
    r = p[SclW-1] ? SclW'(-r) : r;
    return r[PixW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld[NSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q[15:0] <= itm[NSteps].l;
      if (itm[NSteps].grey) begin
        out_data_q[31:16] <= itm[NSteps].a;
        out_data_q[47:32] <= itm[NSteps].b;
      end else begin
        out_data_q[31:16] <= scale_trunc(itm[NSteps].a, itm[NSteps].lo);
        out_data_q[47:32] <= scale_trunc(itm[NSteps].b, itm[NSteps].lo);
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
